// ===== rtl/sosp_pkg.sv =====
// shared types, codes and object lookup tables for the sensor object stream parser
package sosp_pkg;

   typedef enum logic [2:0] {
      PH_IDLE    = 3'd0,
      PH_MAC     = 3'd1,
      PH_FIRST   = 3'd2,
      PH_OBJID   = 3'd3,
      PH_LEN     = 3'd4,
      PH_DATA    = 3'd5,
      PH_STOPPED = 3'd6,
      PH_ENC     = 3'd7
   } phase_type;

   localparam logic [2:0] ST_COMPLETE   = 3'd0;
   localparam logic [2:0] ST_NO_PAYLOAD = 3'd1;
   localparam logic [2:0] ST_UNKNOWN_ID = 3'd2;
   localparam logic [2:0] ST_TRUNCATED  = 3'd3;
   localparam logic [2:0] ST_ENCRYPTED  = 3'd4;

   localparam logic [7:0] ID_LEN_A = 8'h53;
   localparam logic [7:0] ID_LEN_B = 8'h54;
   localparam logic [2:0] MAC_BYTES = 3'd6;

   localparam int RSP_DATA_W = 64;

   typedef struct packed {
      logic                  meas;
      logic                  done;
      logic [RSP_DATA_W-1:0] data;
   } rsp_type;

   // fixed data length of an object id, zero when unknown
   function automatic logic [2:0] obj_length(input logic [7:0] id);
      logic [2:0] n;
      case (id)
         8'h00, 8'h01, 8'h0F, 8'h10, 8'h11, 8'h15, 8'h16, 8'h17, 8'h18, 8'h19,
         8'h1A, 8'h1B, 8'h1C, 8'h1D, 8'h1E, 8'h1F, 8'h20, 8'h21, 8'h22, 8'h23,
         8'h24, 8'h25, 8'h26, 8'h27, 8'h28, 8'h29, 8'h2A, 8'h2B, 8'h2C, 8'h2D,
         8'h2E, 8'h2F, 8'h3A, 8'h57, 8'h58, 8'h60: n = 3'd1;
         8'h02, 8'h03, 8'h08, 8'h0C, 8'h12, 8'h13, 8'h14, 8'h3C, 8'h3F, 8'h40,
         8'h41, 8'h43, 8'h44, 8'h45, 8'h46, 8'h47, 8'h48, 8'h51, 8'h52, 8'h56,
         8'h5D, 8'h5E, 8'h5F, 8'h61, 8'hF0: n = 3'd2;
         8'h04, 8'h05, 8'h0A, 8'h0B, 8'h42, 8'h49, 8'h4B, 8'hF2: n = 3'd3;
         8'h3E, 8'h4C, 8'h4D, 8'h4E, 8'h4F, 8'h50, 8'h5B, 8'h5C, 8'h62, 8'h63,
         8'hF1: n = 3'd4;
         default: n = 3'd0;
      endcase
      return n;
   endfunction

   function automatic logic [2:0] obj_scale(input logic [7:0] id);
      logic [2:0] s;
      case (id)
         8'h3F, 8'h41, 8'h45, 8'h46, 8'h47, 8'h4A, 8'h5F: s = 3'd1;
         8'h02, 8'h03, 8'h04, 8'h05, 8'h08, 8'h0B, 8'h14, 8'h44, 8'h5C,
         8'h5E: s = 3'd2;
         8'h0A, 8'h0C, 8'h42, 8'h43, 8'h4B, 8'h4C, 8'h4D, 8'h4E, 8'h4F, 8'h51,
         8'h52, 8'h5D: s = 3'd3;
         8'h62, 8'h63: s = 3'd4;
         default: s = 3'd0;
      endcase
      return s;
   endfunction

   function automatic logic obj_signed(input logic [7:0] id);
      logic sg;
      case (id)
         8'h02, 8'h08, 8'h3F, 8'h45, 8'h57, 8'h58, 8'h5A, 8'h5B, 8'h5C, 8'h5D,
         8'h62, 8'h63: sg = 1'b1;
         default: sg = 1'b0;
      endcase
      return sg;
   endfunction

endpackage

// ===== rtl/sensor_object_stream_parser.sv =====
// sensor object stream parser: decodes service-data frames byte by byte into object values
//
// request channel: one frame byte per request on req_tdata, req_tuser marks the
// header byte that opens a frame, req_tlast marks the frame's last byte.
// response channel: rsp_tuser set when the response carries a finished object
// measurement, rsp_tlast set on the response for a frame's last byte (then the
// frame status field is valid). a byte may yield no response at all.
// a byte's response is registered in the output register, or in the skid entry
// while that is full. one byte per cycle while req_tready is high, from the table
// decode and shift-accumulate on the parser state registers.
// the response side has an output register plus one skid entry, so bytes keep
// flowing while a response waits; req_tready drops only once the skid entry
// is also holding a response that the receiver has not taken.
// reset clears the parser to wait for a header byte and empties the response
// stages; bytes that arrive outside a frame are dropped silently.
module sensor_object_stream_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tuser,   // frame_start
   input  logic        req_tlast,   // frame_end
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [7:0] object_id, [40:8] raw_value, [48:41] data_length, [51:49] scale_code,
   // [52] is_signed, [55:53] frame_status, [58:56] version, [59] encrypted,
   // [60] trigger_based, [63:61] zero
   output logic [63:0] rsp_tdata,
   output logic        rsp_tuser,   // measurement_valid
   output logic        rsp_tlast    // frame_done
);

   sosp_pkg::phase_type phase_ff, phase_in, phase_mid;
   logic [2:0]  skip_ff, skip_in;
   logic [7:0]  obj_ff, obj_in;
   logic [7:0]  len_ff, len_in;
   logic [7:0]  rem_ff, rem_in;
   logic [31:0] acc_ff, acc_in;
   logic        enc_ff, enc_in;
   logic        trig_ff, trig_in;
   logic [2:0]  ver_ff, ver_in;

   logic        accept;
   logic        active;
   logic        meas;
   logic        produce;
   logic [2:0]  status;
   logic [7:0]  byte_idx;
   logic [2:0]  tab_len;
   logic        sg;
   logic        sx;
   logic [32:0] raw;
   sosp_pkg::rsp_type new_rsp;

   logic              out_valid_ff, skid_valid_ff;
   sosp_pkg::rsp_type out_ff, skid_ff;
   logic              pop;
   logic              new_valid;

   assign accept   = req_tvalid && req_tready;
   assign tab_len  = sosp_pkg::obj_length(req_tdata);
   assign byte_idx = len_ff - rem_ff;

   always_comb begin
      phase_mid = phase_ff;
      skip_in   = skip_ff;
      obj_in    = obj_ff;
      len_in    = len_ff;
      rem_in    = rem_ff;
      acc_in    = acc_ff;
      enc_in    = enc_ff;
      trig_in   = trig_ff;
      ver_in    = ver_ff;
      meas      = 1'b0;
      status    = sosp_pkg::ST_COMPLETE;
      active    = req_tuser || (phase_ff != sosp_pkg::PH_IDLE);

      if (req_tuser) begin
         enc_in    = req_tdata[0];
         trig_in   = req_tdata[2];
         ver_in    = req_tdata[7:5];
         skip_in   = 3'd0;
         phase_mid = req_tdata[1] ? sosp_pkg::PH_MAC : sosp_pkg::PH_FIRST;
      end else begin
         case (phase_ff)
            sosp_pkg::PH_MAC: begin
               skip_in = skip_ff + 3'd1;
               if (skip_in >= sosp_pkg::MAC_BYTES) begin
                  phase_mid = sosp_pkg::PH_FIRST;
               end
            end
            sosp_pkg::PH_FIRST, sosp_pkg::PH_OBJID: begin
               if (phase_ff == sosp_pkg::PH_FIRST && enc_ff) begin
                  phase_mid = sosp_pkg::PH_ENC;
               end else begin
                  obj_in = req_tdata;
                  if (req_tdata == sosp_pkg::ID_LEN_A || req_tdata == sosp_pkg::ID_LEN_B) begin
                     phase_mid = sosp_pkg::PH_LEN;
                  end else if (tab_len == 3'd0) begin
                     phase_mid = sosp_pkg::PH_STOPPED;
                  end else begin
                     len_in    = {5'd0, tab_len};
                     rem_in    = {5'd0, tab_len};
                     acc_in    = 32'd0;
                     phase_mid = sosp_pkg::PH_DATA;
                  end
               end
            end
            sosp_pkg::PH_LEN: begin
               len_in = req_tdata;
               rem_in = req_tdata;
               acc_in = 32'd0;
               if (req_tdata == 8'd0) begin
                  meas      = 1'b1;
                  phase_mid = sosp_pkg::PH_OBJID;
               end else begin
                  phase_mid = sosp_pkg::PH_DATA;
               end
            end
            sosp_pkg::PH_DATA: begin
               // only the first four data bytes land in the value
               if (byte_idx < 8'd4) begin
                  acc_in = acc_ff | ({24'd0, req_tdata} << {byte_idx[1:0], 3'b000});
               end
               rem_in = rem_ff - 8'd1;
               if (rem_in == 8'd0) begin
                  meas      = 1'b1;
                  phase_mid = sosp_pkg::PH_OBJID;
               end
            end
            default: begin
            end
         endcase
      end

      phase_in = phase_mid;
      if (req_tlast) begin
         case (phase_mid)
            sosp_pkg::PH_MAC, sosp_pkg::PH_FIRST: status = sosp_pkg::ST_NO_PAYLOAD;
            sosp_pkg::PH_OBJID:                   status = sosp_pkg::ST_COMPLETE;
            sosp_pkg::PH_LEN, sosp_pkg::PH_DATA:  status = sosp_pkg::ST_TRUNCATED;
            sosp_pkg::PH_STOPPED:                 status = sosp_pkg::ST_UNKNOWN_ID;
            default:                              status = sosp_pkg::ST_ENCRYPTED;
         endcase
         phase_in = sosp_pkg::PH_IDLE;
      end
   end

   assign produce = active && (meas || req_tlast);

   // mask to the object length and sign-extend signed objects to 33 bits; other lengths give zero
   always_comb begin
      sg  = sosp_pkg::obj_signed(obj_ff);
      sx  = 1'b0;
      raw = 33'd0;
      case (len_in)
         8'd1: begin
            sx  = sg && acc_in[7];
            raw = {{25{sx}}, acc_in[7:0]};
         end
         8'd2: begin
            sx  = sg && acc_in[15];
            raw = {{17{sx}}, acc_in[15:0]};
         end
         8'd3: begin
            sx  = sg && acc_in[23];
            raw = {{9{sx}}, acc_in[23:0]};
         end
         8'd4: begin
            sx  = sg && acc_in[31];
            raw = {sx, acc_in};
         end
         default: begin
            sx  = 1'b0;
            raw = 33'd0;
         end
      endcase
   end

   always_comb begin
      new_rsp.meas = meas;
      new_rsp.done = req_tlast;
      new_rsp.data = {3'd0, trig_in, enc_in, ver_in,
                      req_tlast ? status : 3'd0,
                      meas ? sg : 1'b0,
                      meas ? sosp_pkg::obj_scale(obj_ff) : 3'd0,
                      meas ? len_in : 8'd0,
                      meas ? raw : 33'd0,
                      meas ? obj_ff : 8'd0};
   end

   // parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= sosp_pkg::PH_IDLE;
      end else if (accept) begin
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         skip_ff <= skip_in;
         obj_ff  <= obj_in;
         len_ff  <= len_in;
         rem_ff  <= rem_in;
         acc_ff  <= acc_in;
         enc_ff  <= enc_in;
         trig_ff <= trig_in;
         ver_ff  <= ver_in;
      end
   end

   // output register with one skid entry behind it
   assign req_tready = !skid_valid_ff;
   assign pop        = out_valid_ff && rsp_tready;
   assign new_valid  = accept && produce;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!out_valid_ff || pop) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= new_valid;
         end else begin
            out_valid_ff  <= new_valid;
         end
      end else if (new_valid) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!out_valid_ff || pop) begin
         if (skid_valid_ff) begin
            out_ff  <= skid_ff;
            skid_ff <= new_rsp;
         end else begin
            out_ff  <= new_rsp;
         end
      end else if (new_valid) begin
         skid_ff <= new_rsp;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_ff.data;
   assign rsp_tuser  = out_ff.meas;
   assign rsp_tlast  = out_ff.done;

endmodule

// ===== tb/sv/tb_top.sv =====
// self-checking bench for the sensor object stream parser: byte frames in, checked responses out
module tb_top;

   localparam int STALL_CYCLES = 60;
   localparam int CYCLE_LIMIT  = 200000;

   typedef logic [7:0] byte_q_type[$];

   typedef struct {
      logic        meas;
      logic [7:0]  obj_id;
      logic [32:0] raw;
      logic [7:0]  len;
      logic [2:0]  scale;
      logic        sgn;
      logic        done;
      logic [2:0]  status;
      logic [2:0]  ver;
      logic        enc;
      logic        trig;
   } parse_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;
   logic        req_tuser = 1'b0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tlast;

   // parser state as the bench expects it
   sosp_pkg::phase_type prs_phase = sosp_pkg::PH_IDLE;
   int          mac_seen = 0;
   logic [7:0]  obj_id = 8'h00;
   logic [7:0]  bytes_left = 8'h00;
   logic [7:0]  obj_len = 8'h00;
   logic [31:0] value_acc = 32'h0;
   logic [2:0]  hdr_ver = 3'd0;
   logic        hdr_enc = 1'b0;
   logic        hdr_trig = 1'b0;
   logic [2:0]  halt_status = sosp_pkg::ST_COMPLETE;

   parse_result_type pending_results[$];
   int error_count = 0;
   int items_sent = 0;
   int cycle_count = 0;
   int req_idle_pct = 0;
   int rsp_idle_pct = 0;
   int stalls_asked = 0;
   int stalls_served = 0;
   int stall_left = 0;

   sensor_object_stream_parser dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   function automatic int id_width(input logic [7:0] id);
      case (id)
         8'h00, 8'h01, 8'h0F, 8'h10, 8'h11, 8'h15, 8'h16, 8'h17, 8'h18, 8'h19,
         8'h1A, 8'h1B, 8'h1C, 8'h1D, 8'h1E, 8'h1F, 8'h20, 8'h21, 8'h22, 8'h23,
         8'h24, 8'h25, 8'h26, 8'h27, 8'h28, 8'h29, 8'h2A, 8'h2B, 8'h2C, 8'h2D,
         8'h2E, 8'h2F, 8'h3A, 8'h57, 8'h58, 8'h60: return 1;
         8'h02, 8'h03, 8'h08, 8'h0C, 8'h12, 8'h13, 8'h14, 8'h3C, 8'h3F, 8'h40,
         8'h41, 8'h43, 8'h44, 8'h45, 8'h46, 8'h47, 8'h48, 8'h51, 8'h52, 8'h56,
         8'h5D, 8'h5E, 8'h5F, 8'h61, 8'hF0: return 2;
         8'h04, 8'h05, 8'h0A, 8'h0B, 8'h42, 8'h49, 8'h4B, 8'hF2: return 3;
         8'h3E, 8'h4C, 8'h4D, 8'h4E, 8'h4F, 8'h50, 8'h5B, 8'h5C, 8'h62, 8'h63,
         8'hF1: return 4;
         default: return 0;
      endcase
   endfunction

   function automatic logic [2:0] id_scale(input logic [7:0] id);
      case (id)
         8'h3F, 8'h41, 8'h45, 8'h46, 8'h47, 8'h4A, 8'h5F: return 3'd1;
         8'h02, 8'h03, 8'h04, 8'h05, 8'h08, 8'h0B, 8'h14, 8'h44, 8'h5C,
         8'h5E: return 3'd2;
         8'h0A, 8'h0C, 8'h42, 8'h43, 8'h4B, 8'h4C, 8'h4D, 8'h4E, 8'h4F, 8'h51,
         8'h52, 8'h5D: return 3'd3;
         8'h62, 8'h63: return 3'd4;
         default: return 3'd0;
      endcase
   endfunction

   function automatic logic id_signed(input logic [7:0] id);
      case (id)
         8'h02, 8'h08, 8'h3F, 8'h45, 8'h57, 8'h58, 8'h5A, 8'h5B, 8'h5C, 8'h5D,
         8'h62, 8'h63: return 1'b1;
         default: return 1'b0;
      endcase
   endfunction

   function automatic void start_value(input logic [7:0] n);
      obj_len = n;
      bytes_left = n;
      value_acc = 32'h0;
      prs_phase = (n == 8'd0) ? sosp_pkg::PH_OBJID : sosp_pkg::PH_DATA;
   endfunction

   // advance the expected parser state by one accepted byte
   task automatic parse_byte(input logic [7:0] b, input logic fs, input logic fe);
      parse_result_type r;
      logic          meas;
      logic [2:0]    status;
      logic [7:0]    idx;
      logic [63:0]   mask;
      logic [63:0]   raw;
      meas = 1'b0;
      status = sosp_pkg::ST_COMPLETE;
      if (fs) begin
         hdr_enc = b[0];
         hdr_trig = b[2];
         hdr_ver = b[7:5];
         mac_seen = 0;
         halt_status = sosp_pkg::ST_COMPLETE;
         prs_phase = b[1] ? sosp_pkg::PH_MAC : sosp_pkg::PH_FIRST;
      end else begin
         case (prs_phase)
            sosp_pkg::PH_IDLE: return;
            sosp_pkg::PH_MAC: begin
               mac_seen++;
               if (mac_seen >= sosp_pkg::MAC_BYTES) prs_phase = sosp_pkg::PH_FIRST;
            end
            sosp_pkg::PH_FIRST, sosp_pkg::PH_OBJID: begin
               if (prs_phase == sosp_pkg::PH_FIRST && hdr_enc) begin
                  prs_phase = sosp_pkg::PH_ENC;
               end else begin
                  obj_id = b;
                  if (b == sosp_pkg::ID_LEN_A || b == sosp_pkg::ID_LEN_B) begin
                     prs_phase = sosp_pkg::PH_LEN;
                  end else if (id_width(b) == 0) begin
                     halt_status = sosp_pkg::ST_UNKNOWN_ID;
                     prs_phase = sosp_pkg::PH_STOPPED;
                  end else begin
                     start_value(8'(id_width(b)));
                  end
               end
            end
            sosp_pkg::PH_LEN: begin
               start_value(b);
               meas = (b == 8'd0);
            end
            sosp_pkg::PH_DATA: begin
               idx = obj_len - bytes_left;
               // bytes past the fourth are consumed but not kept
               if (idx < 8'd4) value_acc |= 32'(b) << (8 * idx);
               bytes_left--;
               if (bytes_left == 8'd0) begin
                  meas = 1'b1;
                  prs_phase = sosp_pkg::PH_OBJID;
               end
            end
            default: ;
         endcase
      end

      if (fe) begin
         case (prs_phase)
            sosp_pkg::PH_MAC, sosp_pkg::PH_FIRST: status = sosp_pkg::ST_NO_PAYLOAD;
            sosp_pkg::PH_OBJID:                   status = sosp_pkg::ST_COMPLETE;
            sosp_pkg::PH_LEN, sosp_pkg::PH_DATA:  status = sosp_pkg::ST_TRUNCATED;
            sosp_pkg::PH_STOPPED:                 status = halt_status;
            default:                              status = sosp_pkg::ST_ENCRYPTED;
         endcase
         prs_phase = sosp_pkg::PH_IDLE;
      end

      if (!meas && !fe) return;

      r = '{default: '0};
      if (meas) begin
         raw = 64'd0;
         if (obj_len >= 8'd1 && obj_len <= 8'd4) begin
            mask = (64'd1 << (8 * obj_len)) - 64'd1;
            raw = {32'd0, value_acc} & mask;
            if (id_signed(obj_id) && raw[8 * obj_len - 1]) raw |= ~mask;
         end
         r.meas = 1'b1;
         r.obj_id = obj_id;
         r.raw = raw[32:0];
         r.len = obj_len;
         r.scale = id_scale(obj_id);
         r.sgn = id_signed(obj_id);
      end
      r.done = fe;
      r.status = status;
      r.ver = hdr_ver;
      r.enc = hdr_enc;
      r.trig = hdr_trig;
      pending_results.insert(pending_results.size(), r);
   endtask

   task automatic send_byte(input logic [7:0] b, input logic fs, input logic fe);
      while ($urandom_range(99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= b;
      req_tuser <= fs;
      req_tlast <= fe;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      parse_byte(b, fs, fe);
      items_sent++;
   endtask

   task automatic send_frame(input byte_q_type frm, input bit with_end);
      foreach (frm[i]) send_byte(frm[i], i == 0, with_end && i == frm.size() - 1);
   endtask

   task automatic test_stray_bytes();
      send_byte(8'hFF, 1'b0, 1'b1);
      send_byte(8'h00, 1'b0, 1'b0);
   endtask

   task automatic test_header_only();
      send_frame('{8'hE4}, 1'b1);
   endtask

   // signed 4-byte minimum, zero-length object, object ending on the last byte
   task automatic test_object_values();
      send_frame('{8'h40, 8'h62, 8'h00, 8'h00, 8'h00, 8'h80, 8'h53, 8'h00,
                   8'h0C, 8'h34, 8'h12}, 1'b1);
   endtask

   task automatic test_restart_encrypted();
      send_frame('{8'h02, 8'h11}, 1'b0);
      send_frame('{8'h01, 8'hAB, 8'hCD}, 1'b1);
   endtask

   task automatic test_unknown_id();
      send_frame('{8'h00, 8'hFF, 8'h01}, 1'b1);
   endtask

   task automatic test_missing_length();
      send_frame('{8'h00, 8'h54}, 1'b1);
   endtask

   task automatic test_long_object();
      send_frame('{8'h00, 8'h53, 8'h05, 8'h11, 8'h22, 8'h33, 8'h44, 8'h55}, 1'b1);
   endtask

   task automatic test_random_frames(input int n_items);
      byte_q_type frm;
      logic [7:0] hdr;
      logic [7:0] id;
      int         stop_at;
      int         len;
      int         cut;
      stop_at = items_sent + n_items;
      while (items_sent < stop_at) begin
         if ($urandom_range(99) < 5) send_byte(8'($urandom), 1'b0, 1'($urandom_range(1)));
         hdr = 8'($urandom);
         hdr[0] = ($urandom_range(99) < 15);
         hdr[1] = ($urandom_range(99) < 30);
         frm = '{hdr};
         if (hdr[1]) repeat (sosp_pkg::MAC_BYTES) frm.insert(frm.size(), 8'($urandom));
         repeat ($urandom_range(4)) begin
            id = 8'($urandom);
            if ($urandom_range(9) == 0) begin
               id = $urandom_range(1) ? sosp_pkg::ID_LEN_A : sosp_pkg::ID_LEN_B;
            end else if ($urandom_range(99) < 85) begin
               while (id_width(id) == 0 && id != sosp_pkg::ID_LEN_A
                      && id != sosp_pkg::ID_LEN_B) id = 8'($urandom);
            end
            frm.insert(frm.size(), id);
            if (id == sosp_pkg::ID_LEN_A || id == sosp_pkg::ID_LEN_B) begin
               // mostly short, now and then a long one
               len = ($urandom_range(49) == 0) ? $urandom_range(255, 9) : $urandom_range(8);
               frm.insert(frm.size(), 8'(len));
            end else begin
               len = id_width(id);
            end
            repeat (len) frm.insert(frm.size(), 8'($urandom));
         end
         if ($urandom_range(99) < 12) begin
            cut = $urandom_range(frm.size(), 1);
            frm = frm[0:cut-1];
         end
         send_frame(frm, $urandom_range(99) >= 5);
      end
   endtask

   // receiver holds off while many short objects keep arriving
   task automatic test_backpressure();
      byte_q_type frm;
      frm = '{8'h00};
      repeat (24) begin
         frm.insert(frm.size(), 8'h01);
         frm.insert(frm.size(), 8'($urandom));
      end
      stalls_asked++;
      send_frame(frm, 1'b1);
   endtask

   function automatic void check_field(input string name, input logic [63:0] want,
                                       input logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         error_count++;
      end
   endfunction

   always @(posedge clock) begin
      parse_result_type want;
      if (stalls_served != stalls_asked) begin
         stalls_served = stalls_asked;
         stall_left = STALL_CYCLES;
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            $error("response with no request pending");
            error_count++;
         end else begin
            want = pending_results.pop_front();
            check_field("measurement_valid", want.meas, rsp_tuser);
            check_field("frame_done", want.done, rsp_tlast);
            check_field("object_id", want.obj_id, rsp_tdata[7:0]);
            check_field("raw_value", want.raw, rsp_tdata[40:8]);
            check_field("data_length", want.len, rsp_tdata[48:41]);
            check_field("scale_code", want.scale, rsp_tdata[51:49]);
            check_field("is_signed", want.sgn, rsp_tdata[52]);
            check_field("frame_status", want.status, rsp_tdata[55:53]);
            check_field("version", want.ver, rsp_tdata[58:56]);
            check_field("encrypted", want.enc, rsp_tdata[59]);
            check_field("trigger_based", want.trig, rsp_tdata[60]);
            check_field("pad", 64'd0, rsp_tdata[63:61]);
         end
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      req_idle_pct = 16;
      rsp_idle_pct = 68;
      test_stray_bytes();
      test_header_only();
      test_object_values();
      test_restart_encrypted();
      test_unknown_id();
      test_missing_length();
      test_long_object();
      test_random_frames(140);

      req_idle_pct = 68;
      rsp_idle_pct = 16;
      test_random_frames(140);

      req_idle_pct = 0;
      rsp_idle_pct = 0;
      test_backpressure();
      test_random_frames(140);

      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
